// ----- src/pchr_pkg.sv -----
// Package for the pulse counter with hourly rate: widths, time constants,
// register indexes and the sequencer state type. No dependencies.

package pchr_pkg;

    // Default width of the event counter
    localparam int COUNT_WIDTH_DEF = 32;

    // Field widths
    localparam int PERIOD_W = 16;
    localparam int RCOUNT_W = 32;
    localparam int RATE_W   = 22;
    localparam int TICK_W   = 32;
    localparam int TOTAL_W  = 32;

    // Divider geometry: 22-bit dividend, 32-bit divisor, one quotient bit a cycle
    localparam int DVD_W = RATE_W;
    localparam int DVS_W = TICK_W;
    localparam int DCNT_W = $clog2(DVD_W + 1);

    // Time constants
    localparam int SEC_PER_MIN = 60;
    localparam int MS_PER_SEC  = 1000;
    localparam int HALVES      = 2;
    localparam logic [DVD_W-1:0] MS_PER_HOUR =
        DVD_W'(SEC_PER_MIN * SEC_PER_MIN * MS_PER_SEC);
    localparam logic [DVD_W-1:0] MS_PER_HALF_HOUR =
        DVD_W'(SEC_PER_MIN * SEC_PER_MIN * MS_PER_SEC / HALVES);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TICK_PERIOD   = 2'd0;
    localparam t_cfg_idx CFG_RESTORE_COUNT = 2'd1;
    localparam t_cfg_idx CFG_RESTORE_RATE  = 2'd2;
    localparam int CFG_DATA_W = 32;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;

    // Stream widths, padded to whole bytes
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 56;

    // Per-tick sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HALF_P,
        ST_HALF_R,
        ST_EDGE,
        ST_RATE_P,
        ST_RATE_T,
        ST_FIN
    } t_state;

endpackage

// ----- src/pchr_div.sv -----
// Bit-serial restoring divider for the pulse counter: one quotient bit per
// cycle through a shift register. Uses pchr_pkg for widths.

module pchr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pchr_pkg::DVD_W-1:0] i_dividend,
    input  logic [pchr_pkg::DVS_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [pchr_pkg::DVD_W-1:0] o_quotient
);

    localparam int DVD_W  = pchr_pkg::DVD_W;
    localparam int DVS_W  = pchr_pkg::DVS_W;
    localparam int DCNT_W = pchr_pkg::DCNT_W;

    logic [DVD_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_done;

    logic [DVS_W:0]   trial;
    logic [DVS_W-1:0] n_rem;
    logic             q_bit;

    // Trial subtract of the divisor from the remainder with the next dividend bit
    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]} - {1'b0, r_dvs};
        if (!trial[DVS_W]) begin
            n_rem = trial[DVS_W-1:0];
            q_bit = 1'b1;
        end else begin
            n_rem = {r_rem[DVS_W-2:0], r_quo[DVD_W-1]};
            q_bit = 1'b0;
        end
    end

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= DCNT_W'(DVD_W);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == DCNT_W'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - DCNT_W'(1);
            end
        end
    end

    // Shift dividend bits out at the top, quotient bits in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DVD_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- src/pulse_counter_hourly_rate.sv -----
// Pulse counter with hourly rate measurement. Each transfer on the input stream
// is one scan tick carrying the sampled line level; each tick yields one result
// with the running edge count and the hourly rate of the last edge-to-edge
// interval. A tick without an edge passes through ST_EDGE and ST_FIN, and ST_FIN
// writes its result into the output register once that register is free; the
// sequencer then returns to ST_IDLE to take the next tick. A rising edge adds two
// serial divisions (3600000 / period, then by the ticks since the previous edge);
// the first tick after reset with a nonzero restore rate adds two more divisions
// to seed the tick counter. The bit-serial divider produces one quotient bit per
// cycle over a 22-bit dividend. A finished result waits in the output register
// while the next tick is taken.
// Configuration must be written by the user only while no tick is in flight; the
// block itself does not enforce this. Uses pchr_pkg and pchr_div.

module pulse_counter_hourly_rate #(
    parameter int COUNT_WIDTH = pchr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tick stream; tdata: [0] pulse_level, [7:1] zero
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [pchr_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // result stream; tdata: [31:0] event_total, [53:32] events_per_hour, [55:54] zero
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [pchr_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  pchr_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [pchr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int CW       = COUNT_WIDTH;
    localparam int EW       = (CW > pchr_pkg::TOTAL_W) ? CW : pchr_pkg::TOTAL_W;
    localparam int PERIOD_W = pchr_pkg::PERIOD_W;
    localparam int RATE_W   = pchr_pkg::RATE_W;
    localparam int TICK_W   = pchr_pkg::TICK_W;
    localparam int TOTAL_W  = pchr_pkg::TOTAL_W;
    localparam int DVD_W    = pchr_pkg::DVD_W;
    localparam int DVS_W    = pchr_pkg::DVS_W;
    localparam int OUT_W    = pchr_pkg::OUT_DATA_W;
    localparam int PAD_W    = OUT_W - RATE_W - TOTAL_W;

    // Configuration registers
    logic [PERIOD_W-1:0]             r_period;
    logic [pchr_pkg::RCOUNT_W-1:0]   r_rcount;
    logic [RATE_W-1:0]               r_rrate;

    // Tick state
    pchr_pkg::t_state  r_state, n_state;
    logic              r_first, n_first;
    logic              r_prev, n_prev;
    logic              r_level, n_level;
    logic [TICK_W-1:0] r_ticks, n_ticks;
    logic [CW-1:0]     r_edge, n_edge;
    logic [RATE_W-1:0] r_rate, n_rate;
    logic              r_out_valid, n_out_valid;
    logic [OUT_W-1:0]  r_out_data, n_out_data;

    // Divider hookup
    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;

    logic [PERIOD_W-1:0] period_eff;
    logic [TICK_W-1:0]   ticks_eff;
    logic [EW-1:0]       rcount_wide;
    logic [EW-1:0]       edge_wide;

    pchr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_cfg_ready = 1'b1;

    // Capture configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= pchr_pkg::PERIOD_RST;
            r_rcount <= '0;
            r_rrate  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pchr_pkg::CFG_TICK_PERIOD:   r_period <= i_cfg_data[PERIOD_W-1:0];
                pchr_pkg::CFG_RESTORE_COUNT: r_rcount <= i_cfg_data[pchr_pkg::RCOUNT_W-1:0];
                pchr_pkg::CFG_RESTORE_RATE:  r_rrate  <= i_cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero period and zero tick count both count as one
    assign period_eff  = (r_period == '0) ? PERIOD_W'(1) : r_period;
    assign ticks_eff   = (r_ticks == '0) ? TICK_W'(1) : r_ticks;
    assign rcount_wide = EW'(r_rcount);
    assign edge_wide   = EW'(r_edge);

    assign o_s_axis_tready = (r_state == pchr_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Sequencer: next state, divider requests and datapath updates
    always_comb begin
        n_state      = r_state;
        n_first      = r_first;
        n_prev       = r_prev;
        n_level      = r_level;
        n_ticks      = r_ticks;
        n_edge       = r_edge;
        n_rate       = r_rate;
        n_out_data   = r_out_data;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        div_start    = 1'b0;
        div_dividend = pchr_pkg::MS_PER_HALF_HOUR;
        div_divisor  = DVS_W'(period_eff);

        case (r_state)
            pchr_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_level = i_s_axis_tdata[0];
                    n_state = pchr_pkg::ST_EDGE;
                    // Load restore values on the first tick after reset
                    if (r_first) begin
                        n_first = 1'b0;
                        n_edge  = rcount_wide[CW-1:0];
                        n_rate  = r_rrate;
                        if (r_rrate != '0) begin
                            div_start = 1'b1;
                            n_state   = pchr_pkg::ST_HALF_P;
                        end else begin
                            n_ticks = TICK_W'(1);
                        end
                    end
                end
            end
            pchr_pkg::ST_HALF_P: begin
                if (div_done) begin
                    div_start    = 1'b1;
                    div_dividend = div_quo;
                    div_divisor  = DVS_W'(r_rrate);
                    n_state      = pchr_pkg::ST_HALF_R;
                end
            end
            pchr_pkg::ST_HALF_R: begin
                if (div_done) begin
                    n_ticks = TICK_W'(div_quo);
                    n_state = pchr_pkg::ST_EDGE;
                end
            end
            pchr_pkg::ST_EDGE: begin
                if (!r_prev && r_level) begin
                    n_edge       = r_edge + CW'(1);
                    div_start    = 1'b1;
                    div_dividend = pchr_pkg::MS_PER_HOUR;
                    n_state      = pchr_pkg::ST_RATE_P;
                end else begin
                    n_state = pchr_pkg::ST_FIN;
                end
            end
            pchr_pkg::ST_RATE_P: begin
                if (div_done) begin
                    div_start    = 1'b1;
                    div_dividend = div_quo;
                    div_divisor  = ticks_eff;
                    n_state      = pchr_pkg::ST_RATE_T;
                end
            end
            pchr_pkg::ST_RATE_T: begin
                if (div_done) begin
                    n_rate  = div_quo;
                    n_ticks = '0;
                    n_state = pchr_pkg::ST_FIN;
                end
            end
            pchr_pkg::ST_FIN: begin
                // Hold until the output register is free, then advance the tick count
                if (!r_out_valid || i_m_axis_tready) begin
                    n_prev      = r_level;
                    n_ticks     = (r_ticks == '1) ? r_ticks : r_ticks + TICK_W'(1);
                    n_out_valid = 1'b1;
                    n_out_data  = {PAD_W'(0), r_rate, edge_wide[TOTAL_W-1:0]};
                    n_state     = pchr_pkg::ST_IDLE;
                end
            end
            default: n_state = pchr_pkg::ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pchr_pkg::ST_IDLE;
            r_first     <= 1'b1;
            r_prev      <= 1'b0;
            r_ticks     <= '0;
            r_edge      <= '0;
            r_rate      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_prev      <= n_prev;
            r_ticks     <= n_ticks;
            r_edge      <= n_edge;
            r_rate      <= n_rate;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_level    <= n_level;
        r_out_data <= n_out_data;
    end

endmodule

// ----- test/tb_pulse_counter_hourly_rate.sv -----
`timescale 1ns / 1ps
// Testbench for pulse_counter_hourly_rate: sends scan ticks, predicts the event count and
// hourly rate of every tick and checks each result transfer against that prediction.
// Depends on pchr_pkg and the block's RTL.

module tb_pulse_counter_hourly_rate;

    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 120;
    localparam int MAX_REPORTS   = 10;
    localparam int TRAIN_PHASES  = 6;
    localparam int TRAIN_TICKS   = 230;
    localparam int TOTAL_W       = pchr_pkg::TOTAL_W;
    localparam int RATE_W        = pchr_pkg::RATE_W;
    localparam int PERIOD_W      = pchr_pkg::PERIOD_W;
    localparam int RCOUNT_W      = pchr_pkg::RCOUNT_W;
    localparam int TICK_W        = pchr_pkg::TICK_W;
    localparam int IN_DATA_W     = pchr_pkg::IN_DATA_W;
    localparam int OUT_DATA_W    = pchr_pkg::OUT_DATA_W;
    localparam int CFG_DATA_W    = pchr_pkg::CFG_DATA_W;
    // index past the last register; writes to it must be dropped
    localparam pchr_pkg::t_cfg_idx CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [RATE_W-1:0]  rate;
    } t_tally;

    // block ports
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    pchr_pkg::t_cfg_idx    i_cfg_index     = pchr_pkg::CFG_TICK_PERIOD;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    // predictor copy of the registers and counter state
    logic [PERIOD_W-1:0]   cfg_period        = pchr_pkg::PERIOD_RST;
    logic [RCOUNT_W-1:0]   cfg_restore_count = '0;
    logic [RATE_W-1:0]     cfg_restore_rate  = '0;
    logic                  awaiting_restore  = 1'b1;
    logic                  last_level        = 1'b0;
    logic [TICK_W-1:0]     ticks_since       = '0;
    logic [TOTAL_W-1:0]    edge_total        = '0;
    logic [RATE_W-1:0]     hourly_rate       = '0;

    t_tally tally_q[$];
    t_tally want_tally;
    t_tally seen_tally;
    int     fault_count   = 0;
    bit     burst_mode    = 1'b0;
    bit     hold_request  = 1'b0;

    pulse_counter_hourly_rate DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the counter model by one tick and return the count and rate it shows
    function automatic t_tally count_tick(input logic level);
        logic [31:0] period;
        logic [31:0] span;
        t_tally      res;
        period = (cfg_period == '0) ? 32'd1 : 32'(cfg_period);
        // first tick: load the saved count and rate, seed the tick counter at half an interval
        if (awaiting_restore) begin
            awaiting_restore = 1'b0;
            edge_total       = cfg_restore_count;
            hourly_rate      = cfg_restore_rate;
            if (hourly_rate != '0)
                ticks_since = 32'(pchr_pkg::MS_PER_HALF_HOUR) / period / 32'(hourly_rate);
            else
                ticks_since = 32'd1;
        end
        // rising edge: count it, measure the interval, restart the tick counter
        if (!last_level && level) begin
            span        = (ticks_since == '0) ? 32'd1 : ticks_since;
            edge_total  = edge_total + 32'd1;
            hourly_rate = RATE_W'(32'(pchr_pkg::MS_PER_HOUR) / period / span);
            ticks_since = '0;
        end
        last_level = level;
        if (ticks_since != '1)
            ticks_since = ticks_since + 32'd1;
        res.total = edge_total;
        res.rate  = hourly_rate;
        return res;
    endfunction

    // Offer one tick after a random gap and record its expected result on transfer
    task automatic send_tick(input logic level);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_DATA_W'(level);
        do @(posedge i_clk); while (!o_s_axis_tready);
        tally_q.push_back(count_tick(level));
    endtask

    // Send a train of pulses with random high and low run lengths
    task automatic send_pulse_train(input int n_ticks, input int max_run);
        logic level;
        int   run;
        level = 1'($urandom_range(0, 1));
        run   = 0;
        for (int i = 0; i < n_ticks; i++) begin
            if (run == 0) begin
                level = ~level;
                run   = $urandom_range(1, max_run);
            end
            // drop in a stray level now and then
            if ($urandom_range(0, 15) == 0)
                send_tick(1'($urandom_range(0, 1)));
            else
                send_tick(level);
            run--;
        end
    endtask

    // Write one register through the configuration channel
    task automatic write_reg(input pchr_pkg::t_cfg_idx idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            pchr_pkg::CFG_TICK_PERIOD:   cfg_period        = data[PERIOD_W-1:0];
            pchr_pkg::CFG_RESTORE_COUNT: cfg_restore_count = data[RCOUNT_W-1:0];
            pchr_pkg::CFG_RESTORE_RATE:  cfg_restore_rate  = data[RATE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering ticks and let every pending result come out
    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (tally_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Saved count at its maximum wraps on a first-tick edge; the saved rate above range
    // with the longest period seeds a zero tick count, which the edge must treat as one
    task automatic test_restore_on_first_tick();
        write_reg(pchr_pkg::CFG_TICK_PERIOD, 32'hABCD_FFFF);
        write_reg(pchr_pkg::CFG_RESTORE_COUNT, 32'hFFFF_FFFF);
        write_reg(pchr_pkg::CFG_RESTORE_RATE, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE, $urandom);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        drain_results();
    endtask

    // Shortest period with the tightest edge spacing, a zero period, then the longest period
    task automatic test_rate_extremes();
        write_reg(pchr_pkg::CFG_TICK_PERIOD, 32'd1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        drain_results();
        write_reg(pchr_pkg::CFG_TICK_PERIOD, 32'd0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        drain_results();
        write_reg(pchr_pkg::CFG_TICK_PERIOD, 32'd65535);
        send_tick(1'b0);
        send_tick(1'b1);
        drain_results();
    endtask

    // Hold the result side off for a long stretch while ticks keep coming back to back
    task automatic test_output_backpressure();
        write_reg(pchr_pkg::CFG_TICK_PERIOD, $urandom_range(1, 200));
        hold_request = 1'b1;
        burst_mode   = 1'b1;
        send_pulse_train(40, 3);
        burst_mode   = 1'b0;
        drain_results();
    endtask

    // Random pulse trains over a spread of periods, some phases without idling
    task automatic test_random_trains();
        logic [CFG_DATA_W-1:0] period_pick;
        int                    max_run;
        for (int phase = 0; phase < TRAIN_PHASES; phase++) begin
            max_run = $urandom_range(1, 40);
            case (phase)
                0: begin
                    period_pick = 32'd1;
                    max_run     = 4;
                end
                1: period_pick = $urandom_range(1, 50);
                2: begin
                    period_pick = 32'hFFFF;
                    max_run     = 80;
                end
                3: period_pick = $urandom;
                4: period_pick = 32'd0;
                default: period_pick = $urandom_range(1, 2000);
            endcase
            write_reg(pchr_pkg::CFG_TICK_PERIOD, period_pick);
            write_reg(pchr_pkg::CFG_RESTORE_COUNT, $urandom);
            write_reg(pchr_pkg::CFG_RESTORE_RATE, $urandom);
            if (phase == 3)
                write_reg(CFG_SPARE, $urandom);
            burst_mode = (phase % 3 == 2);
            send_pulse_train(TRAIN_TICKS, max_run);
            burst_mode = 1'b0;
            drain_results();
        end
    endtask

    // Result side: random stall per result, or the long hold when one is asked for
    initial begin : result_sink
        int unsigned stall;
        @(posedge i_rst_n);
        forever begin
            stall = burst_mode ? 0 : $urandom_range(0, 15);
            if (hold_request) begin
                hold_request = 1'b0;
                stall        = HOLD_CYCLES;
            end
            if (stall > 0) begin
                @(negedge i_clk);
                i_m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // Compare each result transfer with the oldest expected tally
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen_tally.total = o_m_axis_tdata[TOTAL_W-1:0];
            seen_tally.rate  = o_m_axis_tdata[TOTAL_W +: RATE_W];
            if (tally_q.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unexpected result: total %0d rate %0d",
                             seen_tally.total, seen_tally.rate);
            end else begin
                want_tally = tally_q.pop_front();
                if (want_tally.total != seen_tally.total ||
                    want_tally.rate != seen_tally.rate) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("mismatch: expected total %0d rate %0d, got total %0d rate %0d",
                                 want_tally.total, want_tally.rate,
                                 seen_tally.total, seen_tally.rate);
                end
            end
        end
    end

    initial begin : main_seq
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_restore_on_first_tick();
        test_rate_extremes();
        test_output_backpressure();
        test_random_trains();
        drain_results();
        if (fault_count == 0 && tally_q.size() == 0)
            $display("pulse_counter_hourly_rate regression: pass");
        else
            $display("pulse_counter_hourly_rate regression: fail");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #20_000_000;
        $display("pulse_counter_hourly_rate regression: fail");
        $finish;
    end

endmodule

// ----- pulse_counter_hourly_rate.f -----
src/pchr_pkg.sv
src/pchr_div.sv
src/pulse_counter_hourly_rate.sv
test/tb_pulse_counter_hourly_rate.sv
